@@ src/ramb_pkg.sv @@
package ramb_pkg;

    localparam int unsigned PIX_W   = 16;
    localparam int unsigned ALPHA_W = 4;
    localparam int unsigned MASK_W  = 2 * ALPHA_W;
    localparam int unsigned CH5_W   = 5;
    localparam int unsigned CH6_W   = 6;

    localparam logic [ALPHA_W-1:0] ALPHA_NONE = 4'd0;
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 4'd15;
    localparam logic [9:0]         ALPHA_ROUND = 10'd7;

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [ALPHA_W-1:0] alpha_t;

    // (bg*(15-a) + fg*a + 7) / 15 on one channel of up to six bits.
    // The sum stays below 1024, so x/15 == ((x+1)*4369) >> 16 exactly;
    // 4369 = 17 * 257, built from two shift-and-add steps.
    function automatic logic [CH6_W-1:0] mix_channel(
        input logic [CH6_W-1:0] bg,
        input logic [CH6_W-1:0] fg,
        input alpha_t           a
    );
        logic [9:0]  sum;
        logic [13:0] t17;
        logic [21:0] t4369;
        sum   = 10'(bg) * 10'(ALPHA_FULL - a) + 10'(fg) * 10'(a) + ALPHA_ROUND;
        t17   = 14'(sum) + (14'(sum) << 4) + 14'd17;
        t4369 = 22'(t17) + (22'(t17) << 8);
        return t4369[21:16];
    endfunction

    function automatic pixel_t panel_swap(input pixel_t v);
        return {v[7:0], v[15:8]};
    endfunction

    // Composite the foreground onto one byte-swapped RGB565 pixel.
    function automatic pixel_t blend_pixel(
        input pixel_t back,
        input pixel_t fore,
        input alpha_t a
    );
        pixel_t           bg;
        pixel_t           fg;
        logic [CH6_W-1:0] r;
        logic [CH6_W-1:0] g;
        logic [CH6_W-1:0] b;
        pixel_t           res;
        bg = panel_swap(back);
        fg = panel_swap(fore);
        r  = mix_channel({1'b0, bg[15:11]}, {1'b0, fg[15:11]}, a);
        g  = mix_channel(bg[10:5], fg[10:5], a);
        b  = mix_channel({1'b0, bg[4:0]}, {1'b0, fg[4:0]}, a);
        if (a == ALPHA_NONE) begin
            res = back;
        end else if (a == ALPHA_FULL) begin
            res = fore;
        end else begin
            res = panel_swap({r[CH5_W-1:0], g, b[CH5_W-1:0]});
        end
        return res;
    endfunction

endpackage

@@ src/rgb565_alpha_mask_blend.sv @@
// Solid-color compositor for byte-swapped RGB565 framebuffer pixels.
//
// Input stream (s_*): each transaction carries one coverage mask byte and
// the two background pixels it covers. The high nibble is the even pixel's
// alpha, the low nibble the odd pixel's. Result stream (m_*): the two blended
// pixels on m_tdata and their write flags on m_tuser; a flag is set when
// that pixel's alpha is nonzero (zero alpha passes the background through).
// The foreground color is loaded through the cfg_* write channel, which is
// always ready; write it only while no transaction is in flight.
//
// Pipeline: the input register loads at the accepting edge, then the blend
// result lands in the output register when that register advances, which
// raises m_tvalid.
// Throughput: one transaction per clock; the two-register pipeline advances
// whenever the output register is empty or is being taken.
// Stall: when m_tready is low the output register holds, the input register
// fills behind it, and s_tready drops once both are occupied; nothing is lost.
// Reset (aresetn low, synchronous): both pipeline stages empty, foreground
// color returns to 0.
module rgb565_alpha_mask_blend (
    input  logic                          aclk,
    input  logic                          aresetn,
    // fore_color
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ramb_pkg::PIX_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] coverage_pair, [23:8] back_even, [39:24] back_odd
    input  logic [39:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] pix_even, [31:16] pix_odd
    output logic [31:0]                   m_tdata,
    // [0] write_even, [1] write_odd
    output logic [1:0]                    m_tuser
);
    import ramb_pkg::*;

    pixel_t              fore_color_reg;

    // input stage
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [MASK_W-1:0]   in_mask_reg;
    pixel_t              in_back_even_reg;
    pixel_t              in_back_odd_reg;

    // output stage
    logic                out_valid_reg;
    logic                out_valid_next;
    pixel_t              out_pix_even_reg;
    pixel_t              out_pix_odd_reg;
    logic                out_write_even_reg;
    logic                out_write_odd_reg;

    logic                out_load;
    logic                in_load;
    alpha_t              alpha_even;
    alpha_t              alpha_odd;

    assign cfg_ready = 1'b1;

    // Advance the output register when it is empty or its result is taken;
    // the input register may refill in the same cycle it hands off.
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    assign alpha_even = in_mask_reg[MASK_W-1:ALPHA_W];
    assign alpha_odd  = in_mask_reg[ALPHA_W-1:0];

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_load) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = in_valid_reg;
        end
    end

    // Control state and the configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fore_color_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                fore_color_reg <= cfg_data;
            end
        end
    end

    // Capture the incoming transaction.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_mask_reg      <= s_tdata[7:0];
            in_back_even_reg <= s_tdata[23:8];
            in_back_odd_reg  <= s_tdata[39:24];
        end
    end

    // Blend both pixels in one pass and hold the result until it is taken.
    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_pix_even_reg   <= blend_pixel(in_back_even_reg, fore_color_reg, alpha_even);
            out_pix_odd_reg    <= blend_pixel(in_back_odd_reg, fore_color_reg, alpha_odd);
            out_write_even_reg <= (alpha_even != ALPHA_NONE);
            out_write_odd_reg  <= (alpha_odd != ALPHA_NONE);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_odd_reg, out_pix_even_reg};
    assign m_tuser  = {out_write_odd_reg, out_write_even_reg};

endmodule
